// ===== rtl/core/e2rm_pkg.sv =====
// Shared types, constants and the arctangent table for the Euler-to-matrix pipeline.
`default_nettype none
package e2rm_pkg;

	// CORDIC geometry
	localparam int STEPS     = 20;
	localparam int TRIG_BITS = 30;
	localparam int ANG_W     = 26;
	localparam int XY_W      = 33;
	localparam int TRIG_W    = 32;

	// angles in 1/65536 degree
	localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;
	localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;

	// CORDIC start vector length, Q.30
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

	typedef logic signed [15:0]       ang_in_t;
	typedef logic signed [ANG_W-1:0]  ang_t;
	typedef logic signed [XY_W-1:0]   xy_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [15:0]       elem_t;

	// stage control handed to each pipeline section
	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

	// atan(2^-i) in degrees times 65536
	function automatic ang_t atan_tab(input int unsigned i);
		ang_t v;
		case (i)
			0:       v = 26'sd2949120;
			1:       v = 26'sd1740967;
			2:       v = 26'sd919879;
			3:       v = 26'sd466945;
			4:       v = 26'sd234379;
			5:       v = 26'sd117304;
			6:       v = 26'sd58666;
			7:       v = 26'sd29335;
			8:       v = 26'sd14668;
			9:       v = 26'sd7334;
			10:      v = 26'sd3667;
			11:      v = 26'sd1833;
			12:      v = 26'sd917;
			13:      v = 26'sd458;
			14:      v = 26'sd229;
			15:      v = 26'sd115;
			16:      v = 26'sd57;
			17:      v = 26'sd29;
			18:      v = 26'sd14;
			19:      v = 26'sd7;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/e2rm_angle.sv =====
// Angle front end: scale, reduce modulo one turn and fold into [-90, +90] degrees.
`default_nettype none
module e2rm_angle #(
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire e2rm_pkg::pipe_ctl_t ctl,
	input  wire e2rm_pkg::ang_in_t  raw [3],
	output logic                    vld,
	output e2rm_pkg::ang_t          ang [3],
	output logic                    flip [3]
);
	import e2rm_pkg::*;

	localparam int KMOD  = 360 << ANGLE_FRAC_BITS;
	localparam int KHALF = 180 << ANGLE_FRAC_BITS;
	localparam int SH    = 16 - ANGLE_FRAC_BITS;
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / KMOD);
	localparam logic signed [45:0] RECIP_S = 46'($signed({1'b0, RECIP[23:0]}));

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [20:0] t_s1 [3];
	logic signed [20:0] t_s2 [3];
	logic signed [8:0]  q_s2 [3];
	logic signed [22:0] r_s3 [3];
	logic signed [24:0] a_s4 [3];
	ang_t               a_s5 [3];
	logic               f_s5 [3];

	logic signed [45:0] prod [3];
	logic signed [22:0] rc [3];
	logic signed [31:0] ctr [3];

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (ctl.en) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// estimate the turn count and correct the remainder
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = 46'(t_s1[k]) * RECIP_S;
			if (r_s3[k] < 0)
				rc[k] = r_s3[k] + 23'(KMOD);
			else if (r_s3[k] >= 23'(KMOD))
				rc[k] = r_s3[k] - 23'(KMOD);
			else
				rc[k] = r_s3[k];
			ctr[k] = 32'(rc[k] - 23'(KHALF)) <<< SH;
		end
	end

	// advance the reduction stages
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int k = 0; k < 3; k++) begin
				t_s1[k] <= 21'(raw[k]) + 21'(KHALF);
				t_s2[k] <= t_s1[k];
				q_s2[k] <= prod[k][40:32];
				r_s3[k] <= 23'(t_s2[k]) - 23'(q_s2[k]) * 23'(KMOD);
				a_s4[k] <= ctr[k][24:0];
				if (26'(a_s4[k]) > DEG90) begin
					a_s5[k] <= 26'(a_s4[k]) - DEG180;
					f_s5[k] <= 1'b1;
				end else if (26'(a_s4[k]) < -DEG90) begin
					a_s5[k] <= 26'(a_s4[k]) + DEG180;
					f_s5[k] <= 1'b1;
				end else begin
					a_s5[k] <= 26'(a_s4[k]);
					f_s5[k] <= 1'b0;
				end
			end
		end
	end

	assign vld  = vld_s5;
	assign ang  = a_s5;
	assign flip = f_s5;

endmodule
`default_nettype wire

// ===== rtl/core/e2rm_cordic.sv =====
// Three-lane rotation-mode CORDIC, one iteration per stage, sine and cosine in Q.30.
`default_nettype none
module e2rm_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire e2rm_pkg::pipe_ctl_t ctl,
	input  wire e2rm_pkg::ang_t     ang [3],
	input  wire logic               flip [3],
	output logic                    vld,
	output e2rm_pkg::trig_t         cosv [3],
	output e2rm_pkg::trig_t         sinv [3]
);
	import e2rm_pkg::*;

	// stage i holds the vector before iteration i
	xy_t   x_s  [0:STEPS][3];
	xy_t   y_s  [0:STEPS][3];
	ang_t  z_s  [0:STEPS][3];
	logic  f_s  [0:STEPS][3];
	logic  v_s  [0:STEPS];
	trig_t c_so [3];
	trig_t s_so [3];
	logic  v_so;

	// load the start vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (ctl.en) begin
			v_s[0] <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int k = 0; k < 3; k++) begin
				x_s[0][k] <= CORDIC_GAIN;
				y_s[0][k] <= '0;
				z_s[0][k] <= ang[k];
				f_s[0][k] <= flip[k];
			end
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (ctl.en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				for (int k = 0; k < 3; k++) begin
					f_s[i+1][k] <= f_s[i][k];
					if (z_s[i][k] >= 0) begin
						x_s[i+1][k] <= x_s[i][k] - (y_s[i][k] >>> i);
						y_s[i+1][k] <= y_s[i][k] + (x_s[i][k] >>> i);
						z_s[i+1][k] <= z_s[i][k] - atan_tab(i);
					end else begin
						x_s[i+1][k] <= x_s[i][k] + (y_s[i][k] >>> i);
						y_s[i+1][k] <= y_s[i][k] - (x_s[i][k] >>> i);
						z_s[i+1][k] <= z_s[i][k] + atan_tab(i);
					end
				end
			end
		end
	end

	// restore the half turn removed by folding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_so <= 1'b0;
		end else if (ctl.en) begin
			v_so <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int k = 0; k < 3; k++) begin
				if (f_s[STEPS][k]) begin
					c_so[k] <= TRIG_W'(-x_s[STEPS][k]);
					s_so[k] <= TRIG_W'(-y_s[STEPS][k]);
				end else begin
					c_so[k] <= TRIG_W'(x_s[STEPS][k]);
					s_so[k] <= TRIG_W'(y_s[STEPS][k]);
				end
			end
		end
	end

	assign vld  = v_so;
	assign cosv = c_so;
	assign sinv = s_so;

endmodule
`default_nettype wire

// ===== rtl/core/e2rm_matrix.sv =====
// Matrix product stages: Q.30 products, sums, rounding and saturation.
`default_nettype none
module e2rm_matrix #(
	parameter int OUT_FRAC_BITS = 14
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire e2rm_pkg::pipe_ctl_t ctl,
	input  wire e2rm_pkg::trig_t    cosv [3],
	input  wire e2rm_pkg::trig_t    sinv [3],
	output logic                    vld,
	output e2rm_pkg::elem_t         m [9]
);
	import e2rm_pkg::*;

	localparam int SH = TRIG_BITS - OUT_FRAC_BITS;
	localparam logic signed [34:0] RND = (SH > 0) ? 35'sd1 <<< (SH - 1) : 35'sd0;
	localparam logic signed [34:0] HI  = (OUT_FRAC_BITS >= 15) ? 35'sd32767
		: 35'sd1 <<< OUT_FRAC_BITS;
	localparam logic signed [34:0] LO  = -HI - ((OUT_FRAC_BITS >= 15) ? 35'sd1 : 35'sd0);

	// lane order: 0 yaw, 1 pitch, 2 roll
	logic  vld_s1, vld_s2, vld_s3, vld_s4;
	trig_t cysp_s1, sysp_s1, cycp_s1, sycp_s1, sycr_s1, sysr_s1;
	trig_t cycr_s1, cysr_s1, cpsr_s1, cpcr_s1, sr_s1, cr_s1;
	logic signed [32:0] nsp_s1, nsp_s2;
	trig_t cycp_s2, sycp_s2, sycr_s2, sysr_s2, cycr_s2, cysr_s2, cpsr_s2, cpcr_s2;
	trig_t a01_s2, a02_s2, a11_s2, a12_s2;
	logic signed [32:0] v_s3 [9];
	elem_t m_s4 [9];

	function automatic trig_t qmul(input trig_t a, input trig_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p[61:30];
	endfunction

	function automatic elem_t finish(input logic signed [32:0] v);
		logic signed [34:0] r;
		r = (35'(v) + RND) >>> SH;
		if (r > HI)
			r = HI;
		if (r < LO)
			r = LO;
		return r[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (ctl.en) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			// first products
			cysp_s1 <= qmul(cosv[0], sinv[1]);
			sysp_s1 <= qmul(sinv[0], sinv[1]);
			cycp_s1 <= qmul(cosv[0], cosv[1]);
			sycp_s1 <= qmul(sinv[0], cosv[1]);
			sycr_s1 <= qmul(sinv[0], cosv[2]);
			sysr_s1 <= qmul(sinv[0], sinv[2]);
			cycr_s1 <= qmul(cosv[0], cosv[2]);
			cysr_s1 <= qmul(cosv[0], sinv[2]);
			cpsr_s1 <= qmul(cosv[1], sinv[2]);
			cpcr_s1 <= qmul(cosv[1], cosv[2]);
			sr_s1   <= sinv[2];
			cr_s1   <= cosv[2];
			nsp_s1  <= -33'(sinv[1]);
			// triple products
			a01_s2  <= qmul(cysp_s1, sr_s1);
			a02_s2  <= qmul(cysp_s1, cr_s1);
			a11_s2  <= qmul(sysp_s1, sr_s1);
			a12_s2  <= qmul(sysp_s1, cr_s1);
			cycp_s2 <= cycp_s1;
			sycp_s2 <= sycp_s1;
			sycr_s2 <= sycr_s1;
			sysr_s2 <= sysr_s1;
			cycr_s2 <= cycr_s1;
			cysr_s2 <= cysr_s1;
			cpsr_s2 <= cpsr_s1;
			cpcr_s2 <= cpcr_s1;
			nsp_s2  <= nsp_s1;
			// element sums
			v_s3[0] <= 33'(cycp_s2);
			v_s3[1] <= 33'(a01_s2) - 33'(sycr_s2);
			v_s3[2] <= 33'(a02_s2) + 33'(sysr_s2);
			v_s3[3] <= 33'(sycp_s2);
			v_s3[4] <= 33'(a11_s2) + 33'(cycr_s2);
			v_s3[5] <= 33'(a12_s2) - 33'(cysr_s2);
			v_s3[6] <= nsp_s2;
			v_s3[7] <= 33'(cpsr_s2);
			v_s3[8] <= 33'(cpcr_s2);
			// round and clamp
			for (int k = 0; k < 9; k++)
				m_s4[k] <= finish(v_s3[k]);
		end
	end

	assign vld = vld_s4;
	assign m   = m_s4;

endmodule
`default_nettype wire

// ===== rtl/core/euler_to_rotation_matrix.sv =====
// Top level: Z-Y-X Euler angles to a Q1.14 rotation matrix, fully pipelined.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   input   | src_valid, src_stall | yaw_deg, pitch_deg, roll_deg
//   output  | dst_valid, dst_stall | m00 m01 m02 m10 m11 m12 m20 m21 m22
//
// One item enters per cycle while no result is held; the stages are angle reduction,
// the CORDIC (vector load, 20 iterations, sign fix), then products and rounding.
// Reset clears only the valid bits; data registers are left as they are.
// A stalled result freezes the whole pipeline, and src_stall then holds high.
`default_nettype none
module euler_to_rotation_matrix #(
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int OUT_FRAC_BITS   = 14
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                src_valid,
	output logic                     src_stall,
	input  wire e2rm_pkg::ang_in_t   yaw_deg,
	input  wire e2rm_pkg::ang_in_t   pitch_deg,
	input  wire e2rm_pkg::ang_in_t   roll_deg,
	output logic                     dst_valid,
	input  wire logic                dst_stall,
	output e2rm_pkg::elem_t          m00,
	output e2rm_pkg::elem_t          m01,
	output e2rm_pkg::elem_t          m02,
	output e2rm_pkg::elem_t          m10,
	output e2rm_pkg::elem_t          m11,
	output e2rm_pkg::elem_t          m12,
	output e2rm_pkg::elem_t          m20,
	output e2rm_pkg::elem_t          m21,
	output e2rm_pkg::elem_t          m22
);
	import e2rm_pkg::*;

	logic      en;
	pipe_ctl_t ctl_ang, ctl_cor, ctl_mat;
	ang_in_t   raw [3];
	ang_t      ang [3];
	logic      flip [3];
	logic      vld_ang, vld_cor, vld_mat;
	trig_t     cosv [3];
	trig_t     sinv [3];
	elem_t     m [9];

	// hold everything while a finished item waits downstream
	assign en        = !(dst_valid && dst_stall);
	assign src_stall = !en;

	assign raw[0] = yaw_deg;
	assign raw[1] = pitch_deg;
	assign raw[2] = roll_deg;

	assign ctl_ang = '{en: en, vld: src_valid};
	assign ctl_cor = '{en: en, vld: vld_ang};
	assign ctl_mat = '{en: en, vld: vld_cor};

	e2rm_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_angle (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_ang), .raw(raw),
		.vld(vld_ang), .ang(ang), .flip(flip)
	);

	e2rm_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_cor), .ang(ang), .flip(flip),
		.vld(vld_cor), .cosv(cosv), .sinv(sinv)
	);

	e2rm_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_matrix (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_mat), .cosv(cosv), .sinv(sinv),
		.vld(vld_mat), .m(m)
	);

	assign dst_valid = vld_mat;
	assign m00 = m[0];
	assign m01 = m[1];
	assign m02 = m[2];
	assign m10 = m[3];
	assign m11 = m[4];
	assign m12 = m[5];
	assign m20 = m[6];
	assign m21 = m[7];
	assign m22 = m[8];

endmodule
`default_nettype wire

// ===== rtl/core/e2rm_checker.sv =====
// Port-level checks for the Euler-to-matrix pipeline, bound to the top level.
`default_nettype none
module e2rm_checker #(
	parameter int OUT_FRAC_BITS = 14
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        src_valid,
	input wire logic        src_stall,
	input wire logic        dst_valid,
	input wire logic        dst_stall,
	input wire logic [15:0] m00,
	input wire logic [15:0] m20,
	input wire logic [15:0] m22
);
	localparam logic signed [16:0] LIM = (OUT_FRAC_BITS >= 15) ? 17'sd32767
		: 17'sd1 <<< OUT_FRAC_BITS;
	localparam logic signed [16:0] LO  = -LIM - ((OUT_FRAC_BITS >= 15) ? 17'sd1 : 17'sd0);

	// input side stalls exactly when a result is held
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall == (dst_valid && dst_stall))
		else $error("src_stall does not follow the held result");

	// a stalled input item stays offered
	a_hold_src: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_stall |=> src_valid)
		else $error("input item withdrawn while stalled");

	// a held result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid)
		else $error("result dropped while stalled");

	// m00, m20 and m22 of a held result keep their values
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> $stable(m00) && $stable(m20) && $stable(m22))
		else $error("result changed while stalled");

	// m00 and m22 stay within the unit range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> $signed({m00[15], m00}) <= LIM && $signed({m00[15], m00}) >= LO
			&& $signed({m22[15], m22}) <= LIM && $signed({m22[15], m22}) >= LO)
		else $error("matrix element out of range");

endmodule

bind euler_to_rotation_matrix e2rm_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_e2rm_checker (
	.clk(clk), .arst_n(arst_n), .src_valid(src_valid), .src_stall(src_stall),
	.dst_valid(dst_valid), .dst_stall(dst_stall), .m00(m00), .m20(m20), .m22(m22)
);
`default_nettype wire
